/* sv/histogram_median_threshold_defines.svh */
// ----------------------------------------------------------------------------
// histogram_median_threshold_defines.svh
// Assertion macros shared by the histogram median threshold block.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_MEDIAN_THRESHOLD_DEFINES_SVH
`define HISTOGRAM_MEDIAN_THRESHOLD_DEFINES_SVH

// Same-cycle implication, off during reset.
`define HMT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define HMT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hmt_pkg.sv */
// ----------------------------------------------------------------------------
// hmt_pkg
// Types and constants of the histogram median threshold block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hmt_pkg;

  // Default sizes
  localparam int unsigned NUM_SETS_DEF    = 64;
  localparam int unsigned NUM_BINS_DEF    = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Reports cover at most this many sets
  localparam int unsigned MAX_REPORT_SETS = 64;

  // Queue depths
  localparam int unsigned OP_QUEUE_DEPTH     = 4;
  localparam int unsigned REPORT_QUEUE_DEPTH = 2;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_CUTOFF = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_CUTOFF = 2'd1;

  localparam logic [7:0] LOWER_CUTOFF_RESET = 8'd5;
  localparam logic [8:0] UPPER_CUTOFF_RESET = 9'd256;

  // Threshold when the half total is never reached
  localparam logic [8:0] NOT_REACHED = 9'd256;

  typedef struct packed {
    logic [5:0]  set_index;
    logic [15:0] cycles;
    logic        last_sample;
  } sample_t;

  typedef struct packed {
    logic [5:0] set_number;
    logic [8:0] threshold;
    logic       last_of_run;
  } report_t;

  // Classified work handed from front to back
  typedef struct packed {
    logic        counted;
    logic        last;
    logic [5:0]  set_index;
    logic [11:0] bin;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_WAIT,
    ST_SCAN,
    ST_DRAIN
  } back_state_t;

endpackage

`default_nettype wire

/* sv/hmt_ram.sv */
// ----------------------------------------------------------------------------
// hmt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/hmt_fifo.sv */
// ----------------------------------------------------------------------------
// hmt_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/hmt_front.sv */
// ----------------------------------------------------------------------------
// hmt_front
// Holds the cutoff registers, accepts samples and classifies them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmt_front #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned NUM_BINS = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  input  wire hmt_pkg::sample_t                    sample,
  output logic                                     full,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [hmt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [hmt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                init_busy,
  input  wire logic                                op_full,
  output logic                                     op_push,
  output hmt_pkg::op_t                             op
);

  import hmt_pkg::*;

  logic [7:0] lower_cutoff;
  logic [8:0] upper_cutoff;
  logic       counted;
  logic       accept;

  assign cfg_ready = 1'b1;

  // Write cutoff registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_cutoff <= LOWER_CUTOFF_RESET;
      upper_cutoff <= UPPER_CUTOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOWER_CUTOFF: lower_cutoff <= cfg_data[7:0];
        REG_UPPER_CUTOFF: upper_cutoff <= cfg_data[8:0];
        default:          ;
      endcase
    end
  end

  // Hold off samples while the stores are cleared or the queue is full
  assign full   = op_full || init_busy;
  assign accept = push && !full;

  // Count only samples inside the cutoffs and inside the store
  assign counted = (sample.cycles > 16'(lower_cutoff)) &&
                   (sample.cycles < 16'(upper_cutoff)) &&
                   (9'(sample.set_index) < 9'(NUM_SETS)) &&
                   (sample.cycles < 16'(NUM_BINS));

  // Forward work; drop samples that neither count nor end the run
  assign op_push      = accept && (counted || sample.last_sample);
  assign op.counted   = counted;
  assign op.last      = sample.last_sample;
  assign op.set_index = sample.set_index;
  assign op.bin       = sample.cycles[11:0];

endmodule

`default_nettype wire

/* sv/hmt_back.sv */
// ----------------------------------------------------------------------------
// hmt_back
// Updates bin and total counts, scans each set for its median bin and
// clears both stores behind the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmt_back #(
  parameter int unsigned NUM_SETS    = 64,
  parameter int unsigned NUM_BINS    = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hmt_pkg::op_t      op,
  input  wire logic              op_empty,
  output logic                   op_pop,
  input  wire logic              out_full,
  output logic                   out_push,
  output hmt_pkg::report_t       out_item,
  output logic                   init_busy
);

  import hmt_pkg::*;

  localparam int unsigned SetW       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned BinW       = $clog2(NUM_BINS);
  localparam int unsigned BinAddrW   = SetW + BinW;
  localparam int unsigned ReportSets =
    (NUM_SETS < MAX_REPORT_SETS) ? NUM_SETS : MAX_REPORT_SETS;
  localparam int unsigned CW         = COUNT_WIDTH;

  back_state_t     state;
  back_state_t     state_next;
  op_t             op_q;
  logic            reporting;
  logic [SetW-1:0] scan_set;
  logic [BinW-1:0] scan_bin;

  // Data stage of the scan, registered behind the read
  logic            d_valid;
  logic            d_first;
  logic [SetW-1:0] d_set;
  logic [BinW-1:0] d_bin;
  logic [CW-1:0]   sum_q;
  logic [CW-1:0]   half_q;
  logic            found_q;
  logic [8:0]      thr_q;

  // Memory ports
  logic                bin_wr_en;
  logic [BinAddrW-1:0] bin_wr_addr;
  logic [CW-1:0]       bin_wr_data;
  logic                bin_rd_en;
  logic [BinAddrW-1:0] bin_rd_addr;
  logic [CW-1:0]       bin_rd_data;
  logic                tot_wr_en;
  logic [SetW-1:0]     tot_wr_addr;
  logic [CW-1:0]       tot_wr_data;
  logic                tot_rd_en;
  logic [SetW-1:0]     tot_rd_addr;
  logic [CW-1:0]       tot_rd_data;

  // Median search terms
  logic [CW-1:0] half_cur;
  logic [CW-1:0] sum_in;
  logic          found_in;
  logic [8:0]    thr_cur;
  logic [CW:0]   sum_new;
  logic          hit;
  logic [8:0]    thr_new;

  logic last_bin;
  logic last_set;
  logic set_reported;
  logic can_start;

  hmt_ram #(
    .WIDTH (CW),
    .DEPTH (2 ** BinAddrW)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (bin_wr_en),
    .wr_addr (bin_wr_addr),
    .wr_data (bin_wr_data),
    .rd_en   (bin_rd_en),
    .rd_addr (bin_rd_addr),
    .rd_data (bin_rd_data)
  );

  hmt_ram #(
    .WIDTH (CW),
    .DEPTH (2 ** SetW)
  ) u_total_ram (
    .clk     (clk),
    .wr_en   (tot_wr_en),
    .wr_addr (tot_wr_addr),
    .wr_data (tot_wr_data),
    .rd_en   (tot_rd_en),
    .rd_addr (tot_rd_addr),
    .rd_data (tot_rd_data)
  );

  assign last_bin     = (scan_bin == BinW'(NUM_BINS - 1));
  assign last_set     = (scan_set == SetW'(NUM_SETS - 1));
  assign set_reported = reporting && (9'(scan_set) < 9'(ReportSets));
  assign can_start    = !set_reported || !out_full;

  // Running sum against half the total; first beat of a set starts fresh
  assign half_cur = d_first ? (tot_rd_data >> 1) : half_q;
  assign sum_in   = d_first ? '0 : sum_q;
  assign found_in = d_first ? 1'b0 : found_q;
  assign thr_cur  = d_first ? NOT_REACHED : thr_q;
  assign sum_new  = {1'b0, sum_in} + {1'b0, bin_rd_data};
  assign hit      = !found_in && (sum_new >= {1'b0, half_cur});
  assign thr_new  = hit ? 9'(d_bin) : thr_cur;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!op_empty) begin
          if (op.counted) begin
            state_next = ST_WRITE;
          end else if (op.last) begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_WRITE: begin
        state_next = op_q.last ? ST_WAIT : ST_IDLE;
      end
      ST_WAIT: begin
        if (can_start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_bin) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = last_set ? ST_IDLE : ST_WAIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: memory ports, queue handshakes
  always_comb begin
    op_pop      = 1'b0;
    out_push    = 1'b0;
    bin_rd_en   = 1'b0;
    bin_rd_addr = {scan_set, scan_bin};
    tot_rd_en   = 1'b0;
    tot_rd_addr = scan_set;
    bin_wr_en   = 1'b0;
    bin_wr_addr = {d_set, d_bin};
    bin_wr_data = '0;
    tot_wr_en   = 1'b0;
    tot_wr_addr = d_set;
    tot_wr_data = '0;
    case (state)
      ST_IDLE: begin
        op_pop      = !op_empty;
        bin_rd_en   = !op_empty && op.counted;
        bin_rd_addr = {SetW'(op.set_index), BinW'(op.bin)};
        tot_rd_en   = !op_empty && op.counted;
        tot_rd_addr = SetW'(op.set_index);
      end
      ST_WRITE: begin
        bin_wr_en   = 1'b1;
        bin_wr_addr = {SetW'(op_q.set_index), BinW'(op_q.bin)};
        bin_wr_data = (bin_rd_data == {CW{1'b1}}) ? bin_rd_data
                                                  : bin_rd_data + CW'(1);
        tot_wr_en   = 1'b1;
        tot_wr_addr = SetW'(op_q.set_index);
        tot_wr_data = (tot_rd_data == {CW{1'b1}}) ? tot_rd_data
                                                  : tot_rd_data + CW'(1);
      end
      ST_SCAN: begin
        bin_rd_en = 1'b1;
        tot_rd_en = (scan_bin == '0);
      end
      ST_DRAIN: begin
        out_push = set_reported;
      end
      default: ;
    endcase
    // Clear each bin and total behind the scan
    if (d_valid) begin
      bin_wr_en = 1'b1;
      tot_wr_en = d_first;
    end
  end

  assign out_item.set_number  = 6'(d_set);
  assign out_item.threshold   = thr_new;
  assign out_item.last_of_run = (9'(d_set) == 9'(ReportSets - 1));

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT;
      reporting <= 1'b0;
      init_busy <= 1'b1;
      scan_set  <= '0;
      d_valid   <= 1'b0;
    end else begin
      state   <= state_next;
      d_valid <= (state == ST_SCAN);
      if (state_next == ST_WAIT && (state == ST_IDLE || state == ST_WRITE)) begin
        reporting <= 1'b1;
        scan_set  <= '0;
      end
      if (state == ST_DRAIN) begin
        if (last_set) begin
          reporting <= 1'b0;
          init_busy <= 1'b0;
        end else begin
          scan_set <= scan_set + SetW'(1);
        end
      end
    end
  end

  // Payload registers: latched op, scan position, median search
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !op_empty) begin
      op_q <= op;
    end
    if (state == ST_WAIT) begin
      scan_bin <= '0;
    end else if (state == ST_SCAN) begin
      scan_bin <= scan_bin + BinW'(1);
    end
    d_first <= (scan_bin == '0);
    d_set   <= scan_set;
    d_bin   <= scan_bin;
    if (d_valid) begin
      sum_q   <= sum_new[CW-1:0];
      half_q  <= half_cur;
      found_q <= found_in || hit;
      thr_q   <= thr_new;
    end
  end

endmodule

`default_nettype wire

/* sv/histogram_median_threshold.sv */
// ----------------------------------------------------------------------------
// histogram_median_threshold
// Per-set histogram of access times with a median bin report per set.
// ----------------------------------------------------------------------------
// Samples enter on push/full as one sample beat each; reports leave on
// empty/pop, the oldest on the report port while empty is low. Cutoffs are
// written on the cfg channel (index 0 lower, index 1 upper), always ready.
// A counted sample passes the back end's idle state (bin and total RAM read)
// and write state (read-modify-write through the RAM read latency); a sample
// that neither counts nor ends the run is dropped by the front end in its
// accept cycle. A four-entry queue lets the front accept while the back works.
// A sample marked last starts a scan: one bin RAM read per cycle while a set
// is scanned; the scan may wait between sets. The scan zeroes bins and totals
// as it goes. After reset the same pass clears both stores with full held
// high; cfg writes are taken meanwhile.
// When the receiver stalls, the scan waits at the next set boundary until the
// two-entry report queue has room; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "histogram_median_threshold_defines.svh"

module histogram_median_threshold #(
  parameter int unsigned NUM_SETS    = hmt_pkg::NUM_SETS_DEF,
  parameter int unsigned NUM_BINS    = hmt_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = hmt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  input  wire hmt_pkg::sample_t                    sample,
  output logic                                     full,
  output logic                                     empty,
  input  wire logic                                pop,
  output hmt_pkg::report_t                         report,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [hmt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [hmt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import hmt_pkg::*;

  op_t     op_in;
  op_t     op_out;
  logic    op_push;
  logic    op_full;
  logic    op_pop;
  logic    op_empty;
  report_t out_item;
  logic    out_push;
  logic    out_full;
  logic    init_busy;
  logic    run_end_pop;
  logic    run_next_clean;

  hmt_front #(
    .NUM_SETS (NUM_SETS),
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .sample    (sample),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .init_busy (init_busy),
    .op_full   (op_full),
    .op_push   (op_push),
    .op        (op_in)
  );

  hmt_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OP_QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .wdata (op_in),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (op_out),
    .empty (op_empty)
  );

  hmt_back #(
    .NUM_SETS    (NUM_SETS),
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op        (op_out),
    .op_empty  (op_empty),
    .op_pop    (op_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_item),
    .init_busy (init_busy)
  );

  hmt_fifo #(
    .WIDTH ($bits(report_t)),
    .DEPTH (REPORT_QUEUE_DEPTH)
  ) u_report_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_item),
    .full  (out_full),
    .pop   (pop),
    .rdata (report),
    .empty (empty)
  );

  // After the final report of a run, only the next run's first set may follow
  assign run_end_pop    = pop && !empty && report.last_of_run;
  assign run_next_clean = empty || (report.set_number == '0);

  // Checks
  `HMT_ASSERT_IMP(a_op_no_overflow, clk, rst, op_push, !op_full, "op queue overflow")
  `HMT_ASSERT_IMP(a_report_no_overflow, clk, rst, out_push, !out_full, "report queue overflow")
  `HMT_ASSERT_IMP(a_no_report_in_init, clk, rst, init_busy, empty, "report during clear pass")
  `HMT_ASSERT_NXT(a_run_ends_clean, clk, rst, run_end_pop, run_next_clean, "report after end of run")

endmodule

`default_nettype wire
